// ----- hdl/hsfd_pkg.sv -----
// ---------------------------------------------------------------------------
// hsfd_pkg: shared types and constants for the sensor frame decoder
// Frame kinds, beat and result records, scaling constants and the CRC-8 step.
// ---------------------------------------------------------------------------
package hsfd_pkg;

  typedef enum logic [1:0] {
    KIND_TEMP = 2'd0,
    KIND_HUM  = 2'd1,
    KIND_ID1  = 2'd2,
    KIND_ID2  = 2'd3
  } kind_t;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [14:0] TEMP_COEF   = 15'd17572;
  localparam logic [14:0] HUM_COEF    = 15'd12500;
  localparam logic [12:0] TEMP_OFFSET = 13'd4685;
  localparam logic [12:0] HUM_OFFSET  = 13'd600;
  localparam logic [15:0] STATUS_MASK = 16'h0003;

  localparam int unsigned VALUE_W = 15;
  localparam int unsigned IDENT_W = 64;

  // One input beat.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       first;
  } beat_t;

  // One decoded frame.
  typedef struct packed {
    logic                       valid;
    kind_t                      frame_kind;
    logic signed [VALUE_W-1:0]  value;
    logic [IDENT_W-1:0]         ident;
    logic                       crc_error;
    logic                       ident_valid;
  } result_t;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/hsfd_scale.sv -----
// ---------------------------------------------------------------------------
// hsfd_scale: measurement word scaling
// Clear the status bits and convert to centi-degrees or centi-percent.
// ---------------------------------------------------------------------------
module hsfd_scale (
  input  logic [15:0]        raw_word,
  input  logic               humidity,
  output logic signed [14:0] value
);
  import hsfd_pkg::*;

  logic [15:0] raw_m;
  logic [14:0] coef;
  logic [12:0] offset;
  logic [30:0] prod;
  logic [15:0] diff;

  always_comb begin
    raw_m  = raw_word & ~STATUS_MASK;
    coef   = humidity ? HUM_COEF : TEMP_COEF;
    offset = humidity ? HUM_OFFSET : TEMP_OFFSET;
    prod   = {16'h0, coef} * {15'h0, raw_m};
    // divide by 65536: keep the upper bits
    diff   = {1'b0, prod[30:16]} - {3'b000, offset};
    value  = signed'(diff[14:0]);
  end

endmodule

// ----- hdl/hsfd_core.sv -----
// ---------------------------------------------------------------------------
// hsfd_core: frame state and per-byte decode
// Track position, CRC and collected bytes; emit a result when a frame ends.
// ---------------------------------------------------------------------------
module hsfd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hsfd_pkg::beat_t  beat,
  input  logic             crc_check_enable,
  output hsfd_pkg::result_t result
);
  import hsfd_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic        active_r, active_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] raw_r, raw_nxt;
  logic [31:0] mid_r, mid_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic        ferr_r, ferr_nxt;
  logic        b1good_r, b1good_nxt;

  kind_t       kind_e;
  logic        active_e;
  logic [3:0]  pos_e;
  logic [7:0]  crc_e;
  logic        ferr_e;
  logic        b1good_e;
  logic [7:0]  b;
  logic        chk_fail;
  logic signed [14:0] meas_value;

  hsfd_scale u_scale (
    .raw_word (raw_r),
    .humidity (kind_e == KIND_HUM),
    .value    (meas_value)
  );

  always_comb begin
    b        = beat.data_byte;
    kind_e   = beat.first ? beat.kind : kind_r;
    active_e = beat.first | active_r;
    pos_e    = beat.first ? 4'd0 : pos_r;
    crc_e    = beat.first ? 8'h00 : crc_r;
    ferr_e   = beat.first ? 1'b0 : ferr_r;
    b1good_e = (beat.first && beat.kind == KIND_ID1) ? 1'b0 : b1good_r;
    chk_fail = (crc_e != b);

    pos_nxt    = pos_r;
    active_nxt = active_r;
    kind_nxt   = kind_r;
    crc_nxt    = crc_r;
    raw_nxt    = raw_r;
    mid_nxt    = mid_r;
    tail_nxt   = tail_r;
    ferr_nxt   = ferr_r;
    b1good_nxt = b1good_r;
    result     = '0;

    if (step) begin
      kind_nxt   = kind_e;
      active_nxt = active_e;
      pos_nxt    = pos_e;
      crc_nxt    = crc_e;
      ferr_nxt   = ferr_e;
      b1good_nxt = b1good_e;
      if (active_e) begin
        pos_nxt = pos_e + 4'd1;
        unique case (kind_e)
          KIND_TEMP, KIND_HUM: begin
            if (pos_e == 4'd0) begin
              raw_nxt = {b, 8'h00};
              crc_nxt = crc8_byte(crc_e, b);
            end else if (pos_e == 4'd1) begin
              raw_nxt = raw_r | {8'h00, b};
              crc_nxt = crc8_byte(crc_e, b);
            end else begin
              crc_nxt           = 8'h00;
              active_nxt        = 1'b0;
              result.valid      = 1'b1;
              result.value      = meas_value;
              result.crc_error  = crc_check_enable & chk_fail;
            end
          end
          KIND_ID1: begin
            if (!pos_e[0]) begin
              mid_nxt = {mid_r[23:0], b};
              crc_nxt = crc8_byte(crc_e, b);
            end else begin
              crc_nxt  = 8'h00;
              ferr_nxt = ferr_e | chk_fail;
              if (pos_e == 4'd7) begin
                active_nxt       = 1'b0;
                b1good_nxt       = ~ferr_nxt;
                result.valid     = 1'b1;
                result.crc_error = ferr_nxt;
              end
            end
          end
          KIND_ID2: begin
            if (pos_e == 4'd0 || pos_e == 4'd1) begin
              tail_nxt = {tail_r[7:0], b};
              crc_nxt  = crc8_byte(crc_e, b);
            end else if (pos_e == 4'd3 || pos_e == 4'd4) begin
              raw_nxt = {raw_r[7:0], b};
              crc_nxt = crc8_byte(crc_e, b);
            end else begin
              crc_nxt  = 8'h00;
              ferr_nxt = ferr_e | chk_fail;
              if (pos_e != 4'd2) begin
                active_nxt         = 1'b0;
                result.valid       = 1'b1;
                result.crc_error   = ferr_nxt;
                result.ident_valid = b1good_e & ~ferr_nxt;
                if (result.ident_valid) begin
                  result.ident = {raw_r, mid_r, tail_r};
                end
              end
            end
          end
          default: begin
            result = '0;
          end
        endcase
        result.frame_kind = kind_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
      kind_r   <= KIND_TEMP;
      crc_r    <= '0;
      raw_r    <= '0;
      mid_r    <= '0;
      tail_r   <= '0;
      ferr_r   <= 1'b0;
      b1good_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      kind_r   <= kind_nxt;
      crc_r    <= crc_nxt;
      raw_r    <= raw_nxt;
      mid_r    <= mid_nxt;
      tail_r   <= tail_nxt;
      ferr_r   <= ferr_nxt;
      b1good_r <= b1good_nxt;
    end
  end

endmodule

// ----- hdl/humidity_sensor_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// humidity_sensor_frame_decoder: sensor response frame decoder
// Decode measurement and identification frames from a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one response byte per beat. in_tuser carries the frame kind,
//            in_tdata the byte and the first-of-frame flag. A beat with
//            first set opens a new frame and drops any frame in progress.
//   out_*  : one beat per completed frame (temperature, humidity, ident
//            block one, ident block two). Bytes that do not finish a frame,
//            or that arrive with no frame open, give no beat.
//   cfg_*  : write crc_check_enable; always ready. Write only while idle.
// Path: an accepted input beat goes to the input register, then is decoded
//   into the output register before it appears on out_*.
// Throughput: one byte per cycle while out_* does not stall; the input register and the output
//   register each hold a beat, so the input register can take one more
//   beat while a result waits, and the per-byte CRC step plus the constant
//   scaling multiply sit in the single decode stage.
// Reset: clears frame state and the valid flags of both registers; the CRC check comes up on.
// Stall: with out_tready low and a result waiting, the decode stage holds,
//   the input register keeps its beat and in_tready drops.
// ---------------------------------------------------------------------------
module humidity_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] first, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // decoded frames
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [14:0] value, [78:15] ident,
                                  // [79] crc_error, [80] ident_valid, rest zero
  output logic [1:0]  out_tuser,  // [1:0] frame_kind
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // crc_check_enable
);
  import hsfd_pkg::*;

  beat_t   in_beat_r;
  logic    in_vld_r;
  result_t out_r;
  logic    out_vld_r;
  logic    crc_en_r;
  logic    advance;
  result_t core_res;

  // The decode stage moves whenever the output register is free or drained.
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  hsfd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (in_vld_r && advance),
    .beat             (in_beat_r),
    .crc_check_enable (crc_en_r),
    .result           (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      crc_en_r <= cfg_data;
    end
  end

  // Input register: load a new beat whenever there is room.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_beat_r.kind      <= kind_t'(in_tuser);
      in_beat_r.data_byte <= in_tdata[7:0];
      in_beat_r.first     <= in_tdata[8];
    end
  end

  // Output register: take a result only when the stage advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r && core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r && core_res.valid) begin
      out_r <= core_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.frame_kind;
  assign out_tdata  = {7'b0, out_r.ident_valid, out_r.crc_error, out_r.ident,
                       out_r.value};

`ifndef SYNTH
  a_ident_only_block_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.ident_valid) |-> (out_r.frame_kind == KIND_ID2))
    else $error("ident_valid on a frame other than ident block two");

  a_ident_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.ident_valid) |-> (out_r.ident == '0))
    else $error("ident nonzero without ident_valid");

  a_value_zero_for_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.frame_kind == KIND_ID1 || out_r.frame_kind == KIND_ID2))
      |-> (out_r.value == '0))
    else $error("value nonzero on an identification frame");

  a_stalled_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_beat_r)))
    else $error("input register lost a beat during a stall");
`endif

endmodule

// ----- bench/tb_humidity_sensor_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// tb_humidity_sensor_frame_decoder: self-checking bench for the frame decoder
// Drives response bytes on the input stream and keeps a cycle-free model of
// the decoder: CRC-8 per group, measurement scaling and identifier assembly.
// Every result beat is checked field by field against the oldest predicted
// frame. Directed frames come first, then random frames with bad CRCs,
// truncated frames and stray bytes, under random idling on both sides but for a final full-rate stretch.
// ---------------------------------------------------------------------------
module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  // One predicted decoded frame
  typedef struct {
    kind_t       kind;
    logic [14:0] value;
    logic [63:0] ident;
    logic        crc_err;
    logic        id_ok;
  } frame_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [8] first, rest zero
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // [14:0] value, [78:15] ident, [79] crc_error,
                           // [80] ident_valid, rest zero
  logic [1:0]  out_tuser;  // [1:0] frame_kind
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;   // crc_check_enable

  humidity_sensor_frame_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Decoder model state, mirrors the block's frame registers
  logic        crc_on;
  logic [3:0]  m_pos;
  logic        m_open;
  kind_t       m_kind;
  logic [7:0]  m_crc;
  logic [15:0] m_word;
  logic [31:0] m_mid;
  logic [15:0] m_tail;
  logic        m_err;
  logic        m_id1_ok;

  frame_t      frame_q[$];  // decoded frames still owed by the block

  // Bench control and bookkeeping
  bit          src_gaps;
  bit          sink_gaps;
  int          hold_cycles;
  int          mismatches;
  int          beats_sent;
  int          beats_decoded;
  int          frames_checked;
  int          crc_err_frames;
  int          ident_frames;

  // Clock: period 20
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // CRC-8, poly 0x31, MSB first, one data bit per step
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ d[i];
      acc = {acc[6:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Compare a check byte against the group CRC, then restart the group
  task automatic close_group(input logic [7:0] b);
    if (m_crc != b) begin
      m_err = 1'b1;
    end
    m_crc = 8'h00;
  endtask

  // Advance the model by one accepted beat; queue a frame when one completes
  task automatic decode_beat(input logic [1:0] k_in, input logic [7:0] b, input logic first);
    frame_t            f;
    logic [3:0]        pos;
    logic              done;
    logic [15:0]       raw;
    longint unsigned   prod;
    int                val;
    done      = 1'b0;
    val       = 0;
    f.ident   = '0;
    f.crc_err = 1'b0;
    f.id_ok   = 1'b0;
    if (first) begin
      m_kind = kind_t'(k_in);
      m_open = 1'b1;
      m_pos  = 4'd0;
      m_crc  = 8'h00;
      m_err  = 1'b0;
      if (m_kind == KIND_ID1) begin
        m_id1_ok = 1'b0;
      end
    end
    if (m_open) begin
      beats_decoded++;
      pos   = m_pos;
      m_pos = m_pos + 4'd1;
      case (m_kind)
        KIND_TEMP, KIND_HUM: begin
          if (pos == 4'd0) begin
            m_word = {b, 8'h00};
            m_crc  = crc_step(m_crc, b);
          end else if (pos == 4'd1) begin
            m_word[7:0] = b;
            m_crc       = crc_step(m_crc, b);
          end else begin
            // Strip the status bits, then scale and offset
            raw = m_word & ~STATUS_MASK;
            if (m_kind == KIND_TEMP) begin
              prod = longint'(TEMP_COEF) * longint'(raw);
              val  = int'(prod >> 16) - int'(TEMP_OFFSET);
            end else begin
              prod = longint'(HUM_COEF) * longint'(raw);
              val  = int'(prod >> 16) - int'(HUM_OFFSET);
            end
            f.crc_err = crc_on && (m_crc != b);
            m_crc     = 8'h00;
            done      = 1'b1;
          end
        end
        KIND_ID1: begin
          if (!pos[0]) begin
            m_mid = {m_mid[23:0], b};
            m_crc = crc_step(m_crc, b);
          end else begin
            close_group(b);
            if (pos >= 4'd7) begin
              f.crc_err = m_err;
              m_id1_ok  = !m_err;
              done      = 1'b1;
            end
          end
        end
        default: begin
          if (pos == 4'd0 || pos == 4'd1) begin
            m_tail = {m_tail[7:0], b};
            m_crc  = crc_step(m_crc, b);
          end else if (pos == 4'd3 || pos == 4'd4) begin
            m_word = {m_word[7:0], b};
            m_crc  = crc_step(m_crc, b);
          end else begin
            close_group(b);
            if (pos != 4'd2) begin
              f.crc_err = m_err;
              f.id_ok   = m_id1_ok && !m_err;
              if (f.id_ok) begin
                f.ident = {m_word, m_mid, m_tail};
              end
              done = 1'b1;
            end
          end
        end
      endcase
      if (done) begin
        m_open  = 1'b0;
        f.kind  = m_kind;
        f.value = val[14:0];
        frame_q.push_back(f);
      end
    end
  endtask

  // Offer one beat, hold it until accepted, then feed the model
  task automatic send_byte(input logic [1:0] k, input logic [7:0] b, input logic first);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, first, b};
    in_tuser  <= k;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    decode_beat(k, b, first);
  endtask

  // Check byte for a group, bent when asked so the group fails
  function automatic logic [7:0] check_byte(input logic [7:0] crc, input bit bad);
    return bad ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc;
  endfunction

  // Measurement frame: MSB, LSB, CRC
  task automatic send_meas(input kind_t k, input logic [15:0] word, input bit bad);
    logic [7:0] c;
    c = crc_step(crc_step(8'h00, word[15:8]), word[7:0]);
    send_byte(k, word[15:8], 1'b1);
    send_byte(2'($urandom_range(0, 3)), word[7:0], 1'b0);
    send_byte(2'($urandom_range(0, 3)), check_byte(c, bad), 1'b0);
  endtask

  // Ident block one: B3..B0, each followed by its CRC
  task automatic send_id1(input logic [31:0] bytes, input logic [3:0] bad);
    logic [7:0] d;
    for (int i = 3; i >= 0; i--) begin
      d = bytes[i*8 +: 8];
      send_byte((i == 3) ? 2'(KIND_ID1) : 2'($urandom_range(0, 3)), d, i == 3);
      send_byte(2'($urandom_range(0, 3)), check_byte(crc_step(8'h00, d), bad[i]), 1'b0);
    end
  endtask

  // Ident block two: C1 C0 CRC A1 A0 CRC
  task automatic send_id2(input logic [15:0] c_pair, input logic [15:0] a_pair,
                          input logic [1:0] bad);
    send_byte(KIND_ID2, c_pair[15:8], 1'b1);
    send_byte(2'($urandom_range(0, 3)), c_pair[7:0], 1'b0);
    send_byte(2'($urandom_range(0, 3)),
              check_byte(crc_step(crc_step(8'h00, c_pair[15:8]), c_pair[7:0]), bad[0]), 1'b0);
    send_byte(2'($urandom_range(0, 3)), a_pair[15:8], 1'b0);
    send_byte(2'($urandom_range(0, 3)), a_pair[7:0], 1'b0);
    send_byte(2'($urandom_range(0, 3)),
              check_byte(crc_step(crc_step(8'h00, a_pair[15:8]), a_pair[7:0]), bad[1]), 1'b0);
  endtask

  // Drop valid, wait for every owed frame, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write crc_check_enable; call only while idle
  task automatic write_crc_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    crc_on = en;
  endtask

  // Extreme words, stray byte, bad CRC, restart within a frame
  task automatic test_measure_directed();
    send_byte(KIND_HUM, 8'hFF, 1'b0);          // no frame open: ignored
    send_meas(KIND_TEMP, 16'h0000, 1'b0);
    send_meas(KIND_HUM, 16'hFFFF, 1'b1);       // scaled anyway, flagged
    send_byte(KIND_TEMP, 8'hAB, 1'b1);         // dropped by the restart below
    send_meas(KIND_TEMP, 16'hFFFF, 1'b0);
    wait_idle();
  endtask

  // Good ident pair, then block one restarted before block two
  task automatic test_ident_directed();
    send_id1(32'h00FF_A55A, 4'b0000);
    send_id2(16'hFF00, 16'h8001, 2'b00);
    send_byte(KIND_ID1, 8'h12, 1'b1);
    send_byte(KIND_ID1, 8'h34, 1'b0);
    send_id2(16'h1234, 16'h5678, 2'b00);       // block one no longer good
    wait_idle();
  endtask

  // Measurement CRC ignored while the check is off
  task automatic test_crc_disable();
    write_crc_enable(1'b0);
    send_meas(KIND_TEMP, 16'h6666, 1'b1);
    send_meas(KIND_HUM, 16'h0000, 1'b1);
    send_id1(32'hDEAD_BEEF, 4'b0100);          // ident CRC still checked
    wait_idle();
    write_crc_enable(1'b1);
  endtask

  // One well-formed frame of random kind and content; an ident block two often follows a block one
  task automatic send_random_frame();
    kind_t k;
    logic [15:0] w;
    k = kind_t'($urandom_range(0, 3));
    case (k)
      KIND_TEMP, KIND_HUM: begin
        w = 16'($urandom);
        if ($urandom_range(0, 15) == 0) begin
          w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        send_meas(k, w, $urandom_range(0, 7) == 0);
      end
      KIND_ID1: begin
        send_id1($urandom, 4'($urandom_range(0, 7) == 0) << $urandom_range(0, 3));
      end
      default: begin
        if ($urandom_range(0, 9) < 7) begin
          send_id1($urandom, ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'b0000);
        end
        send_id2(16'($urandom), 16'($urandom),
                 ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
      end
    endcase
  endtask

  // Mostly well-formed frames; the rest stray beats and truncated frames
  task automatic test_random(input int n);
    int target;
    int pick;
    target = beats_decoded + n;
    while (beats_decoded < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(2'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 3) == 0);
        end
      end else if (pick == 1) begin
        send_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'b1);
        repeat ($urandom_range(0, 4)) begin
          send_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
        end
      end else begin
        send_random_frame();
      end
    end
    wait_idle();
  endtask

  // Stall the result side long enough that the block backs up into its input
  task automatic test_backpressure();
    bit saved;
    saved    = src_gaps;
    src_gaps = 0;
    hold_cycles = 80;
    repeat (10) begin
      send_meas(kind_t'($urandom_range(0, 1)), 16'($urandom), 1'b0);
    end
    // Pause the sender until every owed frame has drained
    wait_idle();
    src_gaps = saved;
  endtask

  // Result side: long hold-off on request, otherwise random idle bursts
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH frame %0d %s: got %h want %h", frames_checked, what, got, want);
    mismatches++;
  endtask

  // Compare each result beat with the oldest owed frame
  always @(posedge clk) begin : check_frames
    frame_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[78:15], 64'd0);
      end else begin
        e = frame_q.pop_front();
        if (out_tuser !== e.kind) begin
          report_mismatch("frame_kind", 64'(out_tuser), 64'(e.kind));
        end
        if (out_tdata[14:0] !== e.value) begin
          report_mismatch("value", 64'(out_tdata[14:0]), 64'(e.value));
        end
        if (out_tdata[78:15] !== e.ident) begin
          report_mismatch("ident", out_tdata[78:15], e.ident);
        end
        if (out_tdata[79] !== e.crc_err) begin
          report_mismatch("crc_error", 64'(out_tdata[79]), 64'(e.crc_err));
        end
        if (out_tdata[80] !== e.id_ok) begin
          report_mismatch("ident_valid", 64'(out_tdata[80]), 64'(e.id_ok));
        end
        if (e.crc_err) crc_err_frames++;
        if (e.id_ok) ident_frames++;
      end
      frames_checked++;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    crc_on    = 1'b1;
    m_pos     = '0;
    m_open    = 1'b0;
    m_kind    = KIND_TEMP;
    m_crc     = '0;
    m_word    = '0;
    m_mid     = '0;
    m_tail    = '0;
    m_err     = 1'b0;
    m_id1_ok  = 1'b0;
    src_gaps  = 1;
    sink_gaps = 1;
    hold_cycles    = 0;
    mismatches     = 0;
    beats_sent     = 0;
    beats_decoded  = 0;
    frames_checked = 0;
    crc_err_frames = 0;
    ident_frames   = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_measure_directed();
    test_ident_directed();
    test_crc_disable();
    test_backpressure();
    test_random(260);
    write_crc_enable(1'b0);
    test_random(260);
    write_crc_enable(1'b1);
    // Final stretch at full rate on both sides
    src_gaps  = 0;
    sink_gaps = 0;
    test_random(230);
    repeat (10) @(posedge clk);

    $display("Sent %0d beats (%0d inside frames), checked %0d decoded frames",
             beats_sent, beats_decoded, frames_checked);
    $display("Frames flagged with CRC error: %0d, identifiers assembled: %0d",
             crc_err_frames, ident_frames);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
